// ----- rtl/ktor_pkg.sv -----
// Shared types and constants for the keyed table with oldest-entry replacement.
// Used by ktor_store, ktor_ctrl and keyed_table_oldest_replacement; no dependencies.
package ktor_pkg;

    // Table geometry.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of the stream items.
    localparam int WORD_W    = 32;
    localparam int CMD_W     = 3;
    localparam int SLOT_W    = 6;
    localparam int OUT_CNT_W = 7;
    localparam int CMP_W     = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    // Packed stream widths, padded to whole bytes.
    localparam int S_TDATA_RAW = WORD_W + SLOT_W + 3 * WORD_W;
    localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TDATA_RAW = SLOT_W + 4 * WORD_W + OUT_CNT_W;
    localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TUSER_W   = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUT       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_NODE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_DET   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_SLOT = 3'd4;

    // One table entry.
    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] node;
        logic [WORD_W-1:0] stamp;
        logic [WORD_W-1:0] det;
    } entry_t;

    // One input command.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [WORD_W-1:0] key;
        logic [SLOT_W-1:0] slot_index;
        logic [WORD_W-1:0] node_record;
        logic [WORD_W-1:0] send_time;
        logic [WORD_W-1:0] detector_record;
    } item_t;

    // Read request and registered read response of the entry store.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] idx;
        entry_t            entry;
    } rd_rsp_t;

    // Write request with one enable for each word of the entry.
    typedef struct packed {
        logic              en_key;
        logic              en_node;
        logic              en_stamp;
        logic              en_det;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } wr_req_t;

    // Finished result handed to the output register.
    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic                 evicted;
        logic [SLOT_W-1:0]    slot;
        entry_t               entry;
        logic [OUT_CNT_W-1:0] entry_count;
    } result_t;

endpackage

// ----- rtl/ktor_store.sv -----
// Entry store: four word memories with one write port and one registered read port.
// Depends on ktor_pkg.
module ktor_store (
    input  logic              aclk,
    input  logic              aresetn,
    input  ktor_pkg::rd_req_t rd_req,
    input  ktor_pkg::wr_req_t wr_req,
    output ktor_pkg::rd_rsp_t rd_rsp
);

    logic [ktor_pkg::WORD_W-1:0] key_mem   [ktor_pkg::DEPTH];
    logic [ktor_pkg::WORD_W-1:0] node_mem  [ktor_pkg::DEPTH];
    logic [ktor_pkg::WORD_W-1:0] stamp_mem [ktor_pkg::DEPTH];
    logic [ktor_pkg::WORD_W-1:0] det_mem   [ktor_pkg::DEPTH];

    logic                        rd_valid_reg;
    logic [ktor_pkg::ADDR_W-1:0] rd_idx_reg;
    ktor_pkg::entry_t            rd_entry_reg;

    // Word-masked writes.
    always_ff @(posedge aclk) begin
        if (wr_req.en_key) begin
            key_mem[wr_req.addr] <= wr_req.data.key;
        end
        if (wr_req.en_node) begin
            node_mem[wr_req.addr] <= wr_req.data.node;
        end
        if (wr_req.en_stamp) begin
            stamp_mem[wr_req.addr] <= wr_req.data.stamp;
        end
        if (wr_req.en_det) begin
            det_mem[wr_req.addr] <= wr_req.data.det;
        end
    end

    // Registered read data; the index travels with it.
    always_ff @(posedge aclk) begin
        if (rd_req.valid) begin
            rd_idx_reg         <= rd_req.addr;
            rd_entry_reg.key   <= key_mem[rd_req.addr];
            rd_entry_reg.node  <= node_mem[rd_req.addr];
            rd_entry_reg.stamp <= stamp_mem[rd_req.addr];
            rd_entry_reg.det   <= det_mem[rd_req.addr];
        end
    end

    // The response valid flag is control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_req.valid;
        end
    end

    assign rd_rsp.valid = rd_valid_reg;
    assign rd_rsp.idx   = rd_idx_reg;
    assign rd_rsp.entry = rd_entry_reg;

endmodule

// ----- rtl/ktor_ctrl.sv -----
// Sequencer and shared compare unit: scans for a key match and the oldest timestamp
// or fetches a slot, writes a put or update, forms the result. Depends on ktor_pkg.
module ktor_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ktor_pkg::item_t   in_item,
    input  logic              out_free,
    output ktor_pkg::result_t result,
    output ktor_pkg::rd_req_t rd_req,
    output ktor_pkg::wr_req_t wr_req,
    input  ktor_pkg::rd_rsp_t rd_rsp
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_FETCH   = 5'b00100,
        ST_FWAIT   = 5'b01000,
        ST_RESOLVE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [ktor_pkg::CNT_W-1:0]  fill_count_reg, fill_count_next;
    logic [ktor_pkg::CNT_W-1:0]  issue_idx_reg;
    logic                        hit_reg;
    logic [ktor_pkg::ADDR_W-1:0] hit_slot_reg;
    ktor_pkg::entry_t            hit_entry_reg;
    logic [ktor_pkg::WORD_W-1:0] min_time_reg;
    logic [ktor_pkg::ADDR_W-1:0] min_slot_reg;

    logic [ktor_pkg::CMD_W-1:0]  cmd_reg;
    logic [ktor_pkg::WORD_W-1:0] key_reg;
    logic [ktor_pkg::SLOT_W-1:0] si_reg;
    logic [ktor_pkg::WORD_W-1:0] nr_reg;
    logic [ktor_pkg::WORD_W-1:0] st_reg;
    logic [ktor_pkg::WORD_W-1:0] dr_reg;

    logic in_accept;
    logic rsp_scan;
    logic scan_match;
    logic scan_last;
    logic scan_older;
    logic has_room;
    logic in_slot_ok;
    logic commit;

    logic [ktor_pkg::ADDR_W-1:0] res_slot;
    logic                        res_found;
    logic                        res_evicted;
    logic [ktor_pkg::SLOT_W-1:0] res_slot_out;
    ktor_pkg::entry_t            res_entry;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign commit    = (state_reg == ST_RESOLVE) && out_free;

    assign has_room   = (fill_count_reg < ktor_pkg::CNT_W'(ktor_pkg::DEPTH));
    assign in_slot_ok = (ktor_pkg::CMP_W'(in_item.slot_index)
                         < ktor_pkg::CMP_W'(fill_count_reg));

    // Shared compare unit: key equality and timestamp order on each read response.
    assign rsp_scan   = rd_rsp.valid && (state_reg == ST_SCAN);
    assign scan_match = rsp_scan && (rd_rsp.entry.key == key_reg);
    assign scan_last  = rsp_scan && ((ktor_pkg::CNT_W'(rd_rsp.idx) + ktor_pkg::CNT_W'(1))
                                     == fill_count_reg);
    assign scan_older = (rd_rsp.idx == '0) || (rd_rsp.entry.stamp < min_time_reg);

    // Store reads: one per cycle while scanning, or the single slot of a slot read.
    always_comb begin
        rd_req.valid = 1'b0;
        rd_req.addr  = issue_idx_reg[ktor_pkg::ADDR_W-1:0];
        if (state_reg == ST_SCAN) begin
            rd_req.valid = (issue_idx_reg < fill_count_reg);
        end else if (state_reg == ST_FETCH) begin
            rd_req.valid = 1'b1;
            rd_req.addr  = ktor_pkg::ADDR_W'(si_reg);
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    case (in_item.command)
                        ktor_pkg::CMD_PUT, ktor_pkg::CMD_READ,
                        ktor_pkg::CMD_SET_NODE, ktor_pkg::CMD_SET_DET: begin
                            state_next = (fill_count_reg == '0) ? ST_RESOLVE : ST_SCAN;
                        end
                        ktor_pkg::CMD_READ_SLOT: begin
                            state_next = in_slot_ok ? ST_FETCH : ST_RESOLVE;
                        end
                        default: begin
                            state_next = ST_RESOLVE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_match || scan_last) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_FETCH: begin
                state_next = ST_FWAIT;
            end
            ST_FWAIT: begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Resolve the command into a slot, a store write and the result fields.
    always_comb begin
        res_slot        = hit_slot_reg;
        res_found       = 1'b0;
        res_evicted     = 1'b0;
        res_slot_out    = '0;
        res_entry       = '0;
        fill_count_next = fill_count_reg;
        wr_req          = '0;
        case (cmd_reg)
            ktor_pkg::CMD_PUT: begin
                if (hit_reg) begin
                    res_found = 1'b1;
                end else if (has_room) begin
                    res_slot = fill_count_reg[ktor_pkg::ADDR_W-1:0];
                    if (commit) begin
                        fill_count_next = fill_count_reg + ktor_pkg::CNT_W'(1);
                    end
                end else begin
                    res_slot    = min_slot_reg;
                    res_evicted = 1'b1;
                end
                res_slot_out    = ktor_pkg::SLOT_W'(res_slot);
                res_entry.key   = key_reg;
                res_entry.node  = nr_reg;
                res_entry.stamp = st_reg;
                res_entry.det   = dr_reg;
                wr_req.en_key   = commit;
                wr_req.en_node  = commit;
                wr_req.en_stamp = commit;
                wr_req.en_det   = commit;
            end
            ktor_pkg::CMD_READ, ktor_pkg::CMD_SET_NODE, ktor_pkg::CMD_SET_DET: begin
                if (hit_reg) begin
                    res_found    = 1'b1;
                    res_slot_out = ktor_pkg::SLOT_W'(hit_slot_reg);
                    res_entry    = hit_entry_reg;
                    if (cmd_reg == ktor_pkg::CMD_SET_NODE) begin
                        res_entry.node = nr_reg;
                        wr_req.en_node = commit;
                    end else if (cmd_reg == ktor_pkg::CMD_SET_DET) begin
                        res_entry.det = dr_reg;
                        wr_req.en_det = commit;
                    end
                end
            end
            ktor_pkg::CMD_READ_SLOT: begin
                res_found    = hit_reg;
                res_slot_out = si_reg;
                if (hit_reg) begin
                    res_entry = hit_entry_reg;
                end
            end
            default: begin
                res_found = 1'b0;
            end
        endcase
        wr_req.addr = res_slot;
        wr_req.data = res_entry;
    end

    assign result.valid       = commit;
    assign result.found       = res_found;
    assign result.evicted     = res_evicted;
    assign result.slot        = res_slot_out;
    assign result.entry       = res_entry;
    assign result.entry_count = ktor_pkg::OUT_CNT_W'(fill_count_next);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            hit_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            if (in_accept) begin
                hit_reg <= 1'b0;
            end else if (scan_match || (state_reg == ST_FWAIT)) begin
                hit_reg <= 1'b1;
            end
        end
    end

    // Command latch, scan counter, match capture and running minimum.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cmd_reg       <= in_item.command;
            key_reg       <= in_item.key;
            si_reg        <= in_item.slot_index;
            nr_reg        <= in_item.node_record;
            st_reg        <= in_item.send_time;
            dr_reg        <= in_item.detector_record;
            issue_idx_reg <= '0;
        end else if (rd_req.valid && (state_reg == ST_SCAN)) begin
            issue_idx_reg <= issue_idx_reg + ktor_pkg::CNT_W'(1);
        end
        if (scan_match || (state_reg == ST_FWAIT)) begin
            hit_slot_reg  <= rd_rsp.idx;
            hit_entry_reg <= rd_rsp.entry;
        end
        if (rsp_scan && scan_older) begin
            min_time_reg <= rd_rsp.entry.stamp;
            min_slot_reg <= rd_rsp.idx;
        end
    end

    // The fill count never passes the table depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= ktor_pkg::CNT_W'(ktor_pkg::DEPTH))
        else $error("fill count above table depth");

    // The fill count only ever grows by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_count_reg != $past(fill_count_reg))
        |-> (fill_count_reg == $past(fill_count_reg) + ktor_pkg::CNT_W'(1)))
        else $error("fill count changed by other than one");

    // A scan never sees a response from beyond the filled region.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_scan |-> (ktor_pkg::CNT_W'(rd_rsp.idx) < fill_count_reg))
        else $error("scan read an unfilled slot");

    // Eviction only happens on a full table and never together with a hit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (result.valid && result.evicted)
        |-> (!result.found && (fill_count_reg == ktor_pkg::CNT_W'(ktor_pkg::DEPTH))))
        else $error("eviction without a full table");

    // A put that was not a hit always finds a slot on a table with room.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && (cmd_reg == ktor_pkg::CMD_PUT) && !hit_reg && has_room)
        |=> (fill_count_reg == $past(fill_count_reg) + ktor_pkg::CNT_W'(1)))
        else $error("append did not grow the table");

endmodule

// ----- rtl/keyed_table_oldest_replacement.sv -----
// Top level of the keyed table with oldest-entry replacement: stream ports, output register.
// Depends on ktor_pkg, ktor_store and ktor_ctrl.
//
//  Channel | Direction | Transfer condition    | Contents
//  s_*     | in        | s_tvalid & s_tready   | one command: put, read, update or slot read
//  m_*     | out       | m_tvalid & m_tready   | one result for each command
//
// A put, read or update scans the filled entries one per cycle through the store's
// read port and stops at the first key match or after the last filled entry (at most 64);
// on an empty table it resolves without a scan. A slot read of a filled slot fetches that
// slot; other slot reads and other codes go straight to resolving. A new command is
// accepted only when idle. Reset clears the fill count and the sequencer; the entry
// words are not cleared. The result waits in the output register while the next
// command is accepted; a finished command holds its write until that register is free.
module keyed_table_oldest_replacement (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key, slot_index, node_record, send_time, detector_record (from bit 0 up), zero pad
    input  logic [ktor_pkg::S_TDATA_W-1:0] s_tdata,
    // command
    input  logic [ktor_pkg::CMD_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot, key_out, node_out, time_out, detector_out, entry_count (from bit 0 up), zero pad
    output logic [ktor_pkg::M_TDATA_W-1:0] m_tdata,
    // found, evicted
    output logic [ktor_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int W  = ktor_pkg::WORD_W;
    localparam int SW = ktor_pkg::SLOT_W;

    ktor_pkg::item_t   in_item;
    ktor_pkg::result_t result;
    ktor_pkg::rd_req_t rd_req;
    ktor_pkg::wr_req_t wr_req;
    ktor_pkg::rd_rsp_t rd_rsp;

    logic                           m_tvalid_reg;
    logic [ktor_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [ktor_pkg::M_TUSER_W-1:0] m_tuser_reg;
    logic                           out_free;

    // Unpack the input transfer.
    assign in_item.command         = s_tuser;
    assign in_item.key             = s_tdata[W-1:0];
    assign in_item.slot_index      = s_tdata[W+SW-1:W];
    assign in_item.node_record     = s_tdata[2*W+SW-1:W+SW];
    assign in_item.send_time       = s_tdata[3*W+SW-1:2*W+SW];
    assign in_item.detector_record = s_tdata[4*W+SW-1:3*W+SW];

    assign out_free = !m_tvalid_reg || m_tready;

    ktor_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .out_free (out_free),
        .result   (result),
        .rd_req   (rd_req),
        .wr_req   (wr_req),
        .rd_rsp   (rd_rsp)
    );

    ktor_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_req  (rd_req),
        .wr_req  (wr_req),
        .rd_rsp  (rd_rsp)
    );

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (result.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output register payload, packed from bit 0 up.
    always_ff @(posedge aclk) begin
        if (result.valid) begin
            m_tdata_reg <= ktor_pkg::M_TDATA_W'({result.entry_count,
                                                 result.entry.det,
                                                 result.entry.stamp,
                                                 result.entry.node,
                                                 result.entry.key,
                                                 result.slot});
            m_tuser_reg <= {result.evicted, result.found};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
